>>> rtl/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
`timescale 1ns / 1ps

package owbm_pkg;

  // Commands carried by an input beat
  localparam logic [2:0] CmdTick     = 3'd0;
  localparam logic [2:0] CmdReset    = 3'd1;
  localparam logic [2:0] CmdWrite    = 3'd2;
  localparam logic [2:0] CmdRead     = 3'd3;
  localparam logic [2:0] CmdConvert  = 3'd4;
  localparam logic [2:0] CmdReadPad  = 3'd5;
  localparam logic [2:0] CmdStrong   = 3'd6;

  // Completion status codes
  localparam logic [1:0] StatusOk         = 2'd0;
  localparam logic [1:0] StatusNoPresence = 2'd1;
  localparam logic [1:0] StatusStuckLow   = 2'd2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CfgResetLow    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPresWait    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgResetRecov  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgShortPulse  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLongSlot    = 3'd4;

  // Device command bytes
  localparam logic [7:0] RomSkip      = 8'hCC;
  localparam logic [7:0] FnConvert    = 8'h44;
  localparam logic [7:0] FnReadPad    = 8'hBE;

  localparam int unsigned ScratchpadBytes = 9;
  localparam logic [3:0] ScratchLast = 4'(ScratchpadBytes - 1);

  typedef enum logic [9:0] {
    PhIdle     = 10'b00_0000_0001,
    PhRLow     = 10'b00_0000_0010,
    PhRWait    = 10'b00_0000_0100,
    PhRRecOk   = 10'b00_0000_1000,
    PhRRecFail = 10'b00_0001_0000,
    PhWLow     = 10'b00_0010_0000,
    PhWHigh    = 10'b00_0100_0000,
    PhRdLow    = 10'b00_1000_0000,
    PhRdWait   = 10'b01_0000_0000,
    PhRdRec    = 10'b10_0000_0000
  } phase_e;

  typedef enum logic [2:0] {
    SeqNone      = 3'd0,
    SeqConvReset = 3'd1,
    SeqConvSkip  = 3'd2,
    SeqConvFn    = 3'd3,
    SeqPadReset  = 3'd4,
    SeqPadSkip   = 3'd5,
    SeqPadFn     = 3'd6,
    SeqPadData   = 3'd7
  } seq_step_e;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [7:0] presence_wait_time;
    logic [9:0] reset_recovery_time;
    logic [5:0] short_pulse_time;
    logic [7:0] long_slot_time;
  } owbm_cfg_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       strong_on;
    logic       bus_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       drive_high;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] data_out;
    logic       data_valid;
    logic [3:0] data_index;
    logic       data_last;
  } owbm_out_t;

endpackage

>>> rtl/one_wire_master_with_sensor_sequences_core.sv
// Top level of the one-wire bus master: handshakes, config port, result register.
`timescale 1ns / 1ps
//
// One-wire bus master stepped by one-microsecond tick beats.
// Input channel (in_valid_i / in_ready_o / in_data_i): each beat is one tick
// carrying the sampled bus level and an optional command (reset, byte write,
// byte read, convert sequence, scratchpad read sequence, strong pull-up).
// Output channel (out_valid_o / out_ready_i / out_data_o): exactly one result
// beat per input beat, in order, with the bus drive for that tick and any
// done, status or read-byte report.
// Config channel (cfg_valid_i / cfg_ready_o): writes the timing registers;
// always ready, write only while no tick is in flight.
// Result: registered, so it appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle while results are taken; the sequencer resolves
// a whole tick in one pass between its state registers and the result register.
// Stall: while a result waits, in_ready_o is low unless out_ready_i is high,
// so the next tick is taken in the same cycle the result leaves.
// Reset: the bus is released, the sequencer idles, the timing registers load
// their defaults and no result is pending.
//

module one_wire_master_with_sensor_sequences_core
  import owbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  owbm_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output owbm_out_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  owbm_cfg_t cfg;
  owbm_out_t res;
  owbm_out_t out_q;
  logic      out_valid_q, out_valid_d;
  logic      in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  owbm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  owbm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire),
    .in_i   (in_data_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Hold the result until taken; refill on every accepted beat
  assign out_valid_d = in_fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick produced no result");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("finished operation still reports busy");

  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StatusOk) |-> out_data_o.done_res)
    else $error("error status without completion");

  a_last_finishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.data_last |-> out_data_o.data_valid && out_data_o.done_res)
    else $error("last scratchpad byte did not end the sequence");
`endif

endmodule

>>> rtl/owbm_cfg.sv
// Timing register file for the one-wire bus master.
`timescale 1ns / 1ps

module owbm_cfg
  import owbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_index_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output owbm_cfg_t           cfg_o
);

  owbm_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CfgResetLow:   cfg_d.reset_low_time      = wr_data_i;
        CfgPresWait:   cfg_d.presence_wait_time  = wr_data_i[7:0];
        CfgResetRecov: cfg_d.reset_recovery_time = wr_data_i;
        CfgShortPulse: cfg_d.short_pulse_time    = wr_data_i[5:0];
        CfgLongSlot:   cfg_d.long_slot_time      = wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_time      <= 10'd500;
      cfg_q.presence_wait_time  <= 8'd70;
      cfg_q.reset_recovery_time <= 10'd500;
      cfg_q.short_pulse_time    <= 6'd7;
      cfg_q.long_slot_time      <= 8'd70;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/owbm_ctrl.sv
// Bus phase sequencer: state registers and the per-tick next-state logic.
`timescale 1ns / 1ps

module owbm_ctrl
  import owbm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  owbm_in_t  in_i,
  input  owbm_cfg_t cfg_i,
  output owbm_out_t res_o
);

  phase_e     phase_q, phase_d;
  seq_step_e  seq_q, seq_d;
  logic [9:0] timer_q, timer_d;
  logic [2:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] byte_q, byte_d;
  logic       strong_q, strong_d;
  owbm_out_t  res;

  logic [9:0] short_t, long_t;
  assign short_t = 10'(cfg_i.short_pulse_time);
  assign long_t  = 10'(cfg_i.long_slot_time);

  // First slot length of a bit: a one starts with the short low pulse
  function automatic logic [9:0] low_len(input logic b, input logic [9:0] s,
                                         input logic [9:0] l);
    return b ? s : l;
  endfunction

  always_comb begin
    phase_d  = phase_q;
    seq_d    = seq_q;
    timer_d  = timer_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    byte_d   = byte_q;
    strong_d = strong_q;
    res      = '0;

    // Start a command from idle
    if (phase_q == PhIdle && in_i.cmd != CmdTick && in_i.cmd <= CmdStrong) begin
      if (in_i.cmd == CmdStrong) begin
        strong_d     = in_i.strong_on;
        res.done_res = 1'b1;
      end else begin
        strong_d = 1'b0;
        seq_d = (in_i.cmd == CmdConvert) ? SeqConvReset :
                (in_i.cmd == CmdReadPad) ? SeqPadReset  : SeqNone;
        case (in_i.cmd)
          CmdWrite: begin
            shift_d = in_i.data_byte;
            bit_d   = '0;
            phase_d = PhWLow;
            timer_d = low_len(in_i.data_byte[0], short_t, long_t);
          end
          CmdRead: begin
            shift_d = '0;
            bit_d   = '0;
            phase_d = PhRdLow;
            timer_d = short_t;
          end
          default: begin
            if (!in_i.bus_level) begin
              phase_d      = PhIdle;
              seq_d        = SeqNone;
              res.done_res = 1'b1;
              res.status   = StatusStuckLow;
            end else begin
              phase_d = PhRLow;
              timer_d = cfg_i.reset_low_time;
            end
          end
        endcase
      end
    end

    // One microsecond of bus activity
    if (phase_d != PhIdle) begin
      res.drive_low = (phase_d == PhRLow) || (phase_d == PhWLow) || (phase_d == PhRdLow);
      if (timer_d > 10'd1) begin
        timer_d = timer_d - 10'd1;
      end else begin
        unique case (phase_d)
          PhRLow: begin
            phase_d = PhRWait;
            timer_d = 10'(cfg_i.presence_wait_time);
          end
          PhRWait: begin
            phase_d = in_i.bus_level ? PhRRecFail : PhRRecOk;
            timer_d = cfg_i.reset_recovery_time;
          end
          PhRRecOk: begin
            if (seq_d == SeqConvReset || seq_d == SeqPadReset) begin
              seq_d   = (seq_d == SeqConvReset) ? SeqConvSkip : SeqPadSkip;
              shift_d = RomSkip;
              bit_d   = '0;
              phase_d = PhWLow;
              timer_d = low_len(RomSkip[0], short_t, long_t);
            end else begin
              phase_d      = PhIdle;
              seq_d        = SeqNone;
              res.done_res = 1'b1;
            end
          end
          PhRRecFail: begin
            phase_d      = PhIdle;
            seq_d        = SeqNone;
            res.done_res = 1'b1;
            res.status   = StatusNoPresence;
          end
          PhWLow: begin
            phase_d = PhWHigh;
            timer_d = shift_d[0] ? long_t : short_t;
          end
          PhWHigh: begin
            shift_d = {1'b0, shift_d[7:1]};
            if (bit_d == 3'd7) begin
              unique case (seq_d) inside
                SeqConvSkip, SeqPadSkip: begin
                  shift_d = (seq_d == SeqConvSkip) ? FnConvert : FnReadPad;
                  seq_d   = (seq_d == SeqConvSkip) ? SeqConvFn : SeqPadFn;
                  bit_d   = '0;
                  phase_d = PhWLow;
                  timer_d = low_len(shift_d[0], short_t, long_t);
                end
                SeqPadFn: begin
                  seq_d   = SeqPadData;
                  byte_d  = '0;
                  shift_d = '0;
                  bit_d   = '0;
                  phase_d = PhRdLow;
                  timer_d = short_t;
                end
                default: begin
                  phase_d      = PhIdle;
                  seq_d        = SeqNone;
                  res.done_res = 1'b1;
                end
              endcase
            end else begin
              bit_d   = bit_d + 3'd1;
              phase_d = PhWLow;
              timer_d = low_len(shift_d[0], short_t, long_t);
            end
          end
          PhRdLow: begin
            phase_d = PhRdWait;
            timer_d = short_t;
          end
          PhRdWait: begin
            shift_d = {in_i.bus_level, shift_d[7:1]};
            phase_d = PhRdRec;
            timer_d = long_t;
          end
          PhRdRec: begin
            if (bit_d == 3'd7) begin
              res.data_out   = shift_d;
              res.data_valid = 1'b1;
              if (seq_d == SeqPadData) begin
                res.data_index = byte_d;
                res.data_last  = (byte_d >= ScratchLast);
              end
              if (seq_d == SeqPadData && byte_d < ScratchLast) begin
                byte_d  = byte_d + 4'd1;
                shift_d = '0;
                bit_d   = '0;
                phase_d = PhRdLow;
                timer_d = short_t;
              end else begin
                phase_d      = PhIdle;
                seq_d        = SeqNone;
                res.done_res = 1'b1;
              end
            end else begin
              bit_d   = bit_d + 3'd1;
              phase_d = PhRdLow;
              timer_d = short_t;
            end
          end
          default: phase_d = PhIdle;
        endcase
      end
    end

    res.drive_high = strong_d;
    res.busy_res   = (phase_d != PhIdle);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      seq_q    <= SeqNone;
      timer_q  <= '0;
      bit_q    <= '0;
      shift_q  <= '0;
      byte_q   <= '0;
      strong_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      seq_q    <= seq_d;
      timer_q  <= timer_d;
      bit_q    <= bit_d;
      shift_q  <= shift_d;
      byte_q   <= byte_d;
      strong_q <= strong_d;
    end
  end

  assign res_o = res;

endmodule
